// ----- rtl/irss_pkg.sv -----
// Shared types, constants and rounding helpers of the isotropic ray source sampler.
package irss_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int CORDIC_STEPS      = 24;
  localparam int SQRT_STEPS        = 32;
  localparam int CORDIC_TAIL       = SQRT_STEPS - CORDIC_STEPS;

  localparam logic [7:0] SIDE_RESET = 8'd8;
  localparam logic [9:0] DIST_RESET = 10'd100;

  // register byte offsets, decoded on paddr[2]
  localparam logic REG_SQUARE_SIDE     = 1'b0;
  localparam logic REG_SOURCE_DISTANCE = 1'b1;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sh04DBA76D4;

  // arctangent of 2^-i in units where 2^32 is a full turn
  localparam logic [31:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // rotation state of one CORDIC cell
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_t;

  // remainder and root of one square root cell
  typedef struct packed {
    logic [63:0] d;
    logic [63:0] r;
  } sqrt_t;

  // Q24 cm to 1/64 cm, round half up, saturate
  function automatic logic [17:0] to_pos(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = (v + 40'sd131072) >>> 18;
    if (t > 40'sd131071)       return 18'h1FFFF;
    else if (t < -40'sd131072) return 18'h20000;
    else                       return t[17:0];
  endfunction

  // Q31 to Q15, round half up, saturate
  function automatic logic [15:0] to_dir(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd32768) >>> 16;
    if (t > 34'sd32767)       return 16'h7FFF;
    else if (t < -34'sd32768) return 16'h8000;
    else                      return t[15:0];
  endfunction

endpackage

// ----- rtl/irss_if.sv -----
// Word channels of the sampler: random input words and ray result words.
interface irss_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] rand_polar;
  logic [15:0] rand_azimuth;
  logic [15:0] rand_offset_a;
  logic [15:0] rand_offset_b;
  modport source (output valid, rand_polar, rand_azimuth, rand_offset_a, rand_offset_b,
                  input ready);
  modport sink   (input valid, rand_polar, rand_azimuth, rand_offset_a, rand_offset_b,
                  output ready);
endinterface

interface irss_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] pos_x;
  logic [17:0] pos_y;
  logic [17:0] pos_z;
  logic [15:0] dir_x;
  logic [15:0] dir_y;
  logic [15:0] dir_z;
  modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, output ready);
endinterface

// ----- rtl/irss_cordic_cell.sv -----
// One rotation step of the azimuth CORDIC chain, registered.
module irss_cordic_cell import irss_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t c_in,
  output cordic_t c_out_r
);

  cordic_t c_nxt;

  // rotate towards zero residual angle
  always_comb begin
    c_nxt = c_in;
    if (c_in.z >= 34'sd0) begin
      c_nxt.x = c_in.x - (c_in.y >>> STEP);
      c_nxt.y = c_in.y + (c_in.x >>> STEP);
      c_nxt.z = c_in.z - $signed({2'b00, ATAN_TBL[STEP]});
    end else begin
      c_nxt.x = c_in.x + (c_in.y >>> STEP);
      c_nxt.y = c_in.y - (c_in.x >>> STEP);
      c_nxt.z = c_in.z + $signed({2'b00, ATAN_TBL[STEP]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_out_r <= c_nxt;
    end
  end

endmodule

// ----- rtl/irss_sqrt_cell.sv -----
// One digit step of the polar sine square root chain, registered.
module irss_sqrt_cell import irss_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t s_in,
  output sqrt_t s_out_r
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  sqrt_t       s_nxt;
  logic [63:0] trial;

  // restoring square root digit
  always_comb begin
    trial = s_in.r + BIT;
    if (s_in.d >= trial) begin
      s_nxt.d = s_in.d - trial;
      s_nxt.r = (s_in.r >> 1) + BIT;
    end else begin
      s_nxt.d = s_in.d;
      s_nxt.r = s_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_out_r <= s_nxt;
    end
  end

endmodule

// ----- rtl/isotropic_ray_source_sampler_unit.sv -----
// Top level of the isotropic ray source sampler: pipeline, cell chains and registers.
//
//  channel | dir | handshake               | word
//  in_ch   | in  | valid/ready             | rand_polar, rand_azimuth, rand_offset_a/b
//  out_ch  | out | valid/ready             | pos_x/y/z (Q6 cm), dir_x/y/z (Q1.15)
//  cfg     | in  | APB psel/penable/pwrite | square_side @0, source_distance @4
//
// One word in and one out per cycle while out_ch does not stall; the path runs
// through the input register, the 32 cell square root chain (the 24 cell
// CORDIC runs beside it), three multiply/sum stages and the output register.
// Synchronous active-low reset clears the valid bits and presets side and distance.
// A stall on out_ch freezes the whole pipeline; in_ch.ready follows it.
module isotropic_ray_source_sampler_unit import irss_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  irss_in_if.sink     in_ch,
  irss_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [32:0] FMASK = (33'd1 << FRACTION_BITS) - 33'd1;
  localparam int          FSH   = 32 - FRACTION_BITS;
  localparam logic signed [33:0] QTR  = 34'sh040000000;
  localparam logic signed [33:0] HALF = 34'sh080000000;

  logic       en;
  logic [7:0] side_r;
  logic [9:0] dist_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      dist_r <= DIST_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SQUARE_SIDE:     side_r <= pwdata[7:0];
        REG_SOURCE_DISTANCE: dist_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SOURCE_DISTANCE) ? {22'd0, dist_r} : {24'd0, side_r};

  function automatic logic [31:0] turn_of(input logic [15:0] raw);
    return ({16'd0, raw} & FMASK[31:0]) << FSH;
  endfunction

  // global advance: output free or being taken
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // input stage
  logic [31:0]        f1, f2, f3, f4;
  logic signed [31:0] ct_in, oa_in, ob_in;
  logic signed [33:0] z_in;
  cordic_t            c0_nxt;
  logic signed [40:0] oxm, oym;

  always_comb begin
    f1    = turn_of(in_ch.rand_polar);
    f2    = turn_of(in_ch.rand_azimuth);
    f3    = turn_of(in_ch.rand_offset_a);
    f4    = turn_of(in_ch.rand_offset_b);
    ct_in = $signed({~f1[31], f1[30:0]});
    oa_in = $signed({~f3[31], f3[30:0]});
    ob_in = $signed({~f4[31], f4[30:0]});
    z_in  = 34'($signed(f2));
    c0_nxt.x    = CORDIC_GAIN;
    c0_nxt.y    = 34'sd0;
    c0_nxt.z    = z_in;
    c0_nxt.flip = 1'b0;
    // fold beyond a quarter turn by a half turn
    if (z_in > QTR) begin
      c0_nxt.z    = z_in - HALF;
      c0_nxt.flip = 1'b1;
    end else if (z_in < -QTR) begin
      c0_nxt.z    = z_in + HALF;
      c0_nxt.flip = 1'b1;
    end
    oxm = $signed({1'b0, side_r}) * oa_in;
    oym = $signed({1'b0, side_r}) * ob_in;
  end

  logic               v_s1_r;
  logic signed [31:0] ct_s1_r;
  logic signed [63:0] sq_s1_r;
  logic signed [32:0] ox_s1_r, oy_s1_r;
  cordic_t            c_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ct_s1_r <= ct_in;
      sq_s1_r <= ct_in * ct_in;
      ox_s1_r <= 33'(oxm >>> 8);
      oy_s1_r <= 33'(oym >>> 8);
      c_s1_r  <= c0_nxt;
    end
  end

  // cell chains
  sqrt_t   sq_chain [SQRT_STEPS + 1];
  cordic_t cd_chain [CORDIC_STEPS + 1];

  assign sq_chain[0].d = 64'h4000_0000_0000_0000 - sq_s1_r;
  assign sq_chain[0].r = 64'd0;
  assign cd_chain[0]   = c_s1_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    irss_sqrt_cell #(.STEP(k)) u_cell (
      .clk(clk), .en(en), .s_in(sq_chain[k]), .s_out_r(sq_chain[k + 1])
    );
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    irss_cordic_cell #(.STEP(k)) u_cell (
      .clk(clk), .en(en), .c_in(cd_chain[k]), .c_out_r(cd_chain[k + 1])
    );
  end

  // unflip and clamp the CORDIC output on entry to its tail delay
  logic signed [33:0] cx_fix, cy_fix;
  always_comb begin
    cx_fix = cd_chain[CORDIC_STEPS].flip ? -cd_chain[CORDIC_STEPS].x : cd_chain[CORDIC_STEPS].x;
    cy_fix = cd_chain[CORDIC_STEPS].flip ? -cd_chain[CORDIC_STEPS].y : cd_chain[CORDIC_STEPS].y;
    if (cx_fix > HALF)       cx_fix = HALF;
    else if (cx_fix < -HALF) cx_fix = -HALF;
    if (cy_fix > HALF)       cy_fix = HALF;
    else if (cy_fix < -HALF) cy_fix = -HALF;
  end

  logic signed [32:0] cp_d_r [CORDIC_TAIL];
  logic signed [32:0] sp_d_r [CORDIC_TAIL];

  always_ff @(posedge clk) begin
    if (en) begin
      cp_d_r[0] <= cx_fix[32:0];
      sp_d_r[0] <= cy_fix[32:0];
      for (int k = 1; k < CORDIC_TAIL; k++) begin
        cp_d_r[k] <= cp_d_r[k - 1];
        sp_d_r[k] <= sp_d_r[k - 1];
      end
    end
  end

  // side data and valid bits alongside the square root chain
  logic               v_d_r  [SQRT_STEPS];
  logic signed [31:0] ct_d_r [SQRT_STEPS];
  logic signed [32:0] ox_d_r [SQRT_STEPS];
  logic signed [32:0] oy_d_r [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STEPS; k++) v_d_r[k] <= 1'b0;
    end else if (en) begin
      v_d_r[0] <= v_s1_r;
      for (int k = 1; k < SQRT_STEPS; k++) v_d_r[k] <= v_d_r[k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct_d_r[0] <= ct_s1_r;
      ox_d_r[0] <= ox_s1_r;
      oy_d_r[0] <= oy_s1_r;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        ct_d_r[k] <= ct_d_r[k - 1];
        ox_d_r[k] <= ox_d_r[k - 1];
        oy_d_r[k] <= oy_d_r[k - 1];
      end
    end
  end

  // first product stage
  logic signed [32:0] st, cp, sp, ox, oy;
  logic signed [31:0] ct;
  logic signed [65:0] m_stcp, m_stsp, m_oxsp, m_oxcp, m_oyst;
  logic signed [64:0] m_ctcp, m_ctsp;
  logic signed [42:0] m_dct;

  always_comb begin
    st = $signed({1'b0, sq_chain[SQRT_STEPS].r[31:0]});
    cp = cp_d_r[CORDIC_TAIL - 1];
    sp = sp_d_r[CORDIC_TAIL - 1];
    ct = ct_d_r[SQRT_STEPS - 1];
    ox = ox_d_r[SQRT_STEPS - 1];
    oy = oy_d_r[SQRT_STEPS - 1];
    m_stcp = st * cp;
    m_stsp = st * sp;
    m_ctcp = ct * cp;
    m_ctsp = ct * sp;
    m_oxsp = ox * sp;
    m_oxcp = ox * cp;
    m_oyst = oy * st;
    m_dct  = $signed({1'b0, dist_r}) * ct;
  end

  logic               v_p1_r;
  logic signed [33:0] stcp_p1_r, stsp_p1_r, ctcp_p1_r, ctsp_p1_r;
  logic signed [33:0] oxsp_p1_r, oxcp_p1_r, oyst_p1_r;
  logic signed [35:0] dct_p1_r;
  logic signed [32:0] oy_p1_r;
  logic signed [31:0] ct_p1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      stcp_p1_r <= 34'(m_stcp >>> 31);
      stsp_p1_r <= 34'(m_stsp >>> 31);
      ctcp_p1_r <= 34'(m_ctcp >>> 31);
      ctsp_p1_r <= 34'(m_ctsp >>> 31);
      oxsp_p1_r <= 34'(m_oxsp >>> 31);
      oxcp_p1_r <= 34'(m_oxcp >>> 31);
      oyst_p1_r <= 34'(m_oyst >>> 31);
      dct_p1_r  <= 36'(m_dct >>> 7);
      oy_p1_r   <= oy;
      ct_p1_r   <= ct;
    end
  end

  // second product stage
  logic signed [66:0] m_oyctcp, m_oyctsp;
  logic signed [44:0] m_dstcp, m_dstsp;

  always_comb begin
    m_oyctcp = oy_p1_r * ctcp_p1_r;
    m_oyctsp = oy_p1_r * ctsp_p1_r;
    m_dstcp  = $signed({1'b0, dist_r}) * stcp_p1_r;
    m_dstsp  = $signed({1'b0, dist_r}) * stsp_p1_r;
  end

  logic               v_p2_r;
  logic signed [33:0] oyctcp_p2_r, oyctsp_p2_r, oxsp_p2_r, oxcp_p2_r, oyst_p2_r;
  logic signed [37:0] dstcp_p2_r, dstsp_p2_r;
  logic signed [35:0] dct_p2_r;
  logic signed [33:0] stcp_p2_r, stsp_p2_r;
  logic signed [31:0] ct_p2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      oyctcp_p2_r <= 34'(m_oyctcp >>> 31);
      oyctsp_p2_r <= 34'(m_oyctsp >>> 31);
      dstcp_p2_r  <= 38'(m_dstcp >>> 7);
      dstsp_p2_r  <= 38'(m_dstsp >>> 7);
      oxsp_p2_r   <= oxsp_p1_r;
      oxcp_p2_r   <= oxcp_p1_r;
      oyst_p2_r   <= oyst_p1_r;
      dct_p2_r    <= dct_p1_r;
      stcp_p2_r   <= stcp_p1_r;
      stsp_p2_r   <= stsp_p1_r;
      ct_p2_r     <= ct_p1_r;
    end
  end

  // sum stage, Q24 cm
  logic               v_p3_r;
  logic signed [39:0] px_p3_r, py_p3_r, pz_p3_r;
  logic signed [33:0] dx_p3_r, dy_p3_r, dz_p3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_p3_r <= 40'(dstcp_p2_r) + 40'(oyctcp_p2_r) - 40'(oxsp_p2_r);
      py_p3_r <= 40'(dstsp_p2_r) + 40'(oyctsp_p2_r) + 40'(oxcp_p2_r);
      pz_p3_r <= 40'(dct_p2_r) - 40'(oyst_p2_r);
      dx_p3_r <= -stcp_p2_r;
      dy_p3_r <= -stsp_p2_r;
      dz_p3_r <= -34'(ct_p2_r);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r      <= 1'b0;
      v_p1_r      <= 1'b0;
      v_p2_r      <= 1'b0;
      v_p3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_s1_r      <= in_ch.valid;
      v_p1_r      <= v_d_r[SQRT_STEPS - 1];
      v_p2_r      <= v_p1_r;
      v_p3_r      <= v_p2_r;
      out_valid_r <= v_p3_r;
    end
  end

  // output register: round and saturate
  logic [17:0] pos_x_r, pos_y_r, pos_z_r;
  logic [15:0] dir_x_r, dir_y_r, dir_z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x_r <= to_pos(px_p3_r);
      pos_y_r <= to_pos(py_p3_r);
      pos_z_r <= to_pos(pz_p3_r);
      dir_x_r <= to_dir(dx_p3_r);
      dir_y_r <= to_dir(dy_p3_r);
      dir_z_r <= to_dir(dz_p3_r);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = pos_x_r;
  assign out_ch.pos_y = pos_y_r;
  assign out_ch.pos_z = pos_z_r;
  assign out_ch.dir_x = dir_x_r;
  assign out_ch.dir_y = dir_y_r;
  assign out_ch.dir_z = dir_z_r;

endmodule

// ----- tb/tb_isotropic_ray_source_sampler_unit.sv -----
// Self-checking testbench of the isotropic ray source sampler: predictor, stimulus and checks.
module tb_isotropic_ray_source_sampler_unit;
  import irss_pkg::*;

  localparam int  FRAC_BITS   = 16;
  localparam int  DRAIN_WAIT  = 48;     // a little over the pipeline latency
  localparam int  STALL_LIMIT = 20000;  // cycles with no word moving
  localparam longint ONE_Q31  = 64'sd1 <<< 31;

  // register byte addresses
  localparam logic [2:0] ADDR_SIDE = {REG_SQUARE_SIDE, 2'b00};
  localparam logic [2:0] ADDR_DIST = {REG_SOURCE_DISTANCE, 2'b00};

  typedef struct packed {
    logic [15:0] polar;
    logic [15:0] azimuth;
    logic [15:0] off_a;
    logic [15:0] off_b;
  } rand_word_t;

  typedef struct packed {
    logic [17:0] px;
    logic [17:0] py;
    logic [17:0] pz;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
  } ray_word_t;

  // Ray predictor and store of expected rays
  class ray_scoreboard;
    int unsigned side = SIDE_RESET;
    int unsigned dist_cm = DIST_RESET;
    ray_word_t   pending_rays[$];
    int          mismatches;
    int          stray_rays;

    function automatic longint unsigned root62(longint unsigned d);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > d) b = b >> 2;
      while (b != 0) begin
        if (d >= r + b) begin
          d = d - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic longint clamp_q31(longint v);
      if (v > ONE_Q31) return ONE_Q31;
      if (v < -ONE_Q31) return -ONE_Q31;
      return v;
    endfunction

    // rotation-mode CORDIC on a 32 bit turn angle
    function automatic void azimuth_trig(longint turn, output longint c, output longint s);
      longint z, x, y, nx;
      bit     flip;
      int     i;
      z = (turn >= ONE_Q31) ? turn - (64'sd1 <<< 32) : turn;
      x = longint'(CORDIC_GAIN);
      y = 0;
      flip = 0;
      if (z > (64'sd1 <<< 30)) begin
        z = z - ONE_Q31;
        flip = 1;
      end else if (z < -(64'sd1 <<< 30)) begin
        z = z + ONE_Q31;
        flip = 1;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - longint'(ATAN_TBL[i]);
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + longint'(ATAN_TBL[i]);
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = clamp_q31(x);
      s = clamp_q31(y);
    endfunction

    function automatic logic [17:0] pos_q6(longint q24);
      longint v;
      v = (q24 + (64'sd1 <<< 17)) >>> 18;
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v[17:0];
    endfunction

    function automatic logic [15:0] dir_q15(longint q31);
      longint v;
      v = (q31 + (64'sd1 <<< 15)) >>> 16;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function automatic longint turn_of(logic [15:0] raw);
      return longint'(raw) <<< (32 - FRAC_BITS);
    endfunction

    function automatic longint mul31(longint a, longint b);
      return (a * b) >>> 31;
    endfunction

    // work out the ray for one accepted random word
    function void note_input(rand_word_t w);
      longint    ct, st, cp, sp, ox, oy, stcp, stsp, ctcp, ctsp, px, py, pz;
      ray_word_t r;
      ct = turn_of(w.polar) - ONE_Q31;
      st = longint'(root62((64'd1 << 62) - unsigned'(ct * ct)));
      azimuth_trig(turn_of(w.azimuth), cp, sp);
      ox = (longint'(side) * (turn_of(w.off_a) - ONE_Q31)) >>> 8;
      oy = (longint'(side) * (turn_of(w.off_b) - ONE_Q31)) >>> 8;
      stcp = mul31(st, cp);
      stsp = mul31(st, sp);
      ctcp = mul31(ct, cp);
      ctsp = mul31(ct, sp);
      px = -mul31(ox, sp) + mul31(oy, ctcp) + ((longint'(dist_cm) * stcp) >>> 7);
      py = mul31(ox, cp) + mul31(oy, ctsp) + ((longint'(dist_cm) * stsp) >>> 7);
      pz = -mul31(oy, st) + ((longint'(dist_cm) * ct) >>> 7);
      r.px = pos_q6(px);
      r.py = pos_q6(py);
      r.pz = pos_q6(pz);
      r.dx = dir_q15(-stcp);
      r.dy = dir_q15(-stsp);
      r.dz = dir_q15(-ct);
      pending_rays.push_back(r);
    endfunction

    function void check_result(ray_word_t got);
      ray_word_t exp_ray;
      if (pending_rays.size() == 0) begin
        stray_rays++;
        $display("unexpected ray word %h", got);
        return;
      end
      exp_ray = pending_rays.pop_front();
      if (got !== exp_ray) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ray mismatch: exp pos %h %h %h dir %h %h %h, got pos %h %h %h dir %h %h %h",
                   exp_ray.px, exp_ray.py, exp_ray.pz, exp_ray.dx, exp_ray.dy, exp_ray.dz,
                   got.px, got.py, got.pz, got.dx, got.dy, got.dz);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  irss_in_if  in_ch ();
  irss_out_if out_ch ();

  ray_scoreboard sb = new();

  isotropic_ray_source_sampler_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: note accepted random words, check accepted rays
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input({in_ch.rand_polar, in_ch.rand_azimuth,
                     in_ch.rand_offset_a, in_ch.rand_offset_b});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
                       out_ch.dir_x, out_ch.dir_y, out_ch.dir_z});
  end

  // Receiver: cycles through free, light and heavy stalling; one long hold-off
  int unsigned rays_taken;
  int unsigned rx_cycle;
  int unsigned hold_left;
  bit          long_hold_done;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (out_ch.valid && out_ch.ready) rays_taken <= rays_taken + 1;
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_ch.ready  <= 1'b0;
    end else if (!long_hold_done && rays_taken >= 100) begin
      long_hold_done <= 1'b1;
      hold_left      <= 200;
      out_ch.ready   <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(3) != 0);
        default: out_ch.ready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // Watchdog: stop if no word moves for too long
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  int unsigned burst_left;

  task automatic send_word(rand_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.rand_polar    <= w.polar;
    in_ch.rand_azimuth  <= w.azimuth;
    in_ch.rand_offset_a <= w.off_a;
    in_ch.rand_offset_b <= w.off_b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_rays.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned side, int unsigned dist_cm);
    write_reg(ADDR_SIDE, side);
    write_reg(ADDR_DIST, dist_cm);
    sb.side    = side & 8'hFF;
    sb.dist_cm = dist_cm & 10'h3FF;
  endtask

  task automatic random_words(int n);
    rand_word_t w;
    repeat (n) begin
      w = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      send_word(w);
    end
  endtask

  // Directed corners: polar and azimuth extremes, quarter turns, offset extremes
  logic [15:0] corner_val [6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001};

  initial begin
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_ch.valid = 1'b0;
    in_ch.rand_polar    = '0;
    in_ch.rand_azimuth  = '0;
    in_ch.rand_offset_a = '0;
    in_ch.rand_offset_b = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry, directed corners
    for (int i = 0; i < 6; i++)
      send_word({corner_val[i], corner_val[5 - i], corner_val[i], corner_val[(i + 1) % 6]});
    for (int i = 0; i < 6; i++)
      send_word({corner_val[(i + 2) % 6], corner_val[i], corner_val[1], corner_val[0]});
    random_words(300);
    // sender holds off until every ray is back
    drain();
    random_words(80);
    drain();

    // largest square and farthest distance
    set_geometry(255, 1023);
    for (int i = 0; i < 6; i++)
      send_word({corner_val[i], corner_val[(i + 3) % 6], corner_val[1], corner_val[0]});
    random_words(300);
    drain();

    // zero square and zero distance
    set_geometry(0, 0);
    random_words(300);
    drain();

    set_geometry(255, 0);
    random_words(300);
    drain();

    set_geometry(1, 1023);
    random_words(300);
    drain();

    set_geometry($urandom_range(255), $urandom_range(1023));
    random_words(350);
    drain();

    if (sb.mismatches == 0 && sb.stray_rays == 0 && sb.pending_rays.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
